### rtl/digital_watch_controller_assert.svh
// Assertion macros for the watch controller.
`ifndef DIGITAL_WATCH_CONTROLLER_ASSERT_SVH
`define DIGITAL_WATCH_CONTROLLER_ASSERT_SVH

`ifndef SYNTHESIS
`define DWC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define DWC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define DWC_ASSERT(label, clk, rst_n, prop, msg)
`define DWC_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

### rtl/dwc_pkg.sv
package dwc_pkg;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 32;

    localparam logic [5:0] HOURS_TOP   = 6'd23;
    localparam logic [5:0] MINUTES_TOP = 6'd59;
    localparam logic [5:0] SECONDS_TOP = 6'd59;
    localparam logic [3:0] TENTHS_TOP  = 4'd9;
    localparam logic [3:0] BLINK_DIVIDE_RESET = 4'd5;

    typedef enum logic [1:0] {
        MODE_TIME,
        MODE_TSET,
        MODE_ASET,
        MODE_WATCH
    } mode_t;

    typedef enum logic [2:0] {
        EV_NONE,
        EV_PLUS,
        EV_MINUS,
        EV_TIME,
        EV_TIMESET,
        EV_ALARM,
        EV_WATCH
    } ev_t;

    typedef struct packed {
        logic [4:0] h;
        logic [5:0] m;
        logic [5:0] s;
        logic [3:0] t;
    } hmst_t;

    typedef struct packed {
        hmst_t      disp;
        mode_t      mode;
        logic       armed;
        logic       hblink;
        logic       mblink;
        logic       ring;
    } res_t;

    function automatic hmst_t tick_hmst(hmst_t x);
        hmst_t y;
        y = x;
        if (x.t >= TENTHS_TOP) begin
            y.t = 4'd0;
            if (x.s >= SECONDS_TOP) begin
                y.s = 6'd0;
                if (x.m >= MINUTES_TOP) begin
                    y.m = 6'd0;
                    if ({1'b0, x.h} >= HOURS_TOP) begin
                        y.h = 5'd0;
                    end else begin
                        y.h = x.h + 5'd1;
                    end
                end else begin
                    y.m = x.m + 6'd1;
                end
            end else begin
                y.s = x.s + 6'd1;
            end
        end else begin
            y.t = x.t + 4'd1;
        end
        return y;
    endfunction

    function automatic logic [5:0] step_field(logic [5:0] v, logic [5:0] top, logic up);
        logic [5:0] r;
        if (up) begin
            r = (v >= top) ? 6'd0 : v + 6'd1;
        end else begin
            r = (v == 6'd0 || v > top) ? top : v - 6'd1;
        end
        return r;
    endfunction

    function automatic logic [3:0] blink_advance(logic [3:0] c, logic [3:0] bdiv);
        logic [3:0] n;
        n = c + 4'd1;
        if (n >= bdiv || n == 4'd0) begin
            n = 4'd0;
        end
        return n;
    endfunction

endpackage

### rtl/dwc_core.sv
`include "digital_watch_controller_assert.svh"

module dwc_core
    import dwc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [3:0] cfg_wdata,
    input  logic       in_xfer,
    input  logic [5:0] buttons,
    output res_t       res
);

    mode_t      mode_reg, mode_next;
    hmst_t      clk_reg, clk_next;
    hmst_t      watch_reg, watch_next;
    hmst_t      disp_reg, disp_next;
    logic [4:0] alh_reg, alh_next;
    logic [5:0] alm_reg, alm_next;
    logic [3:0] bch_reg, bch_next;
    logic [3:0] bcm_reg, bcm_next;
    logic [3:0] bca_reg, bca_next;
    logic [3:0] bdiv_reg;
    logic       ts_hours_reg, ts_hours_next;
    logic       al_hours_reg, al_hours_next;
    logic       run_reg, run_next;
    logic       lap_reg, lap_next;
    logic       armed_reg, armed_next;
    logic       hb_reg, hb_next;
    logic       mb_reg, mb_next;
    logic       ring_reg, ring_next;
    ev_t        ev;

    always_comb begin
        if (buttons[0]) begin
            ev = EV_PLUS;
        end else if (buttons[1]) begin
            ev = EV_MINUS;
        end else if (buttons[2]) begin
            ev = EV_TIME;
        end else if (buttons[3]) begin
            ev = EV_TIMESET;
        end else if (buttons[4]) begin
            ev = EV_ALARM;
        end else if (buttons[5]) begin
            ev = EV_WATCH;
        end else begin
            ev = EV_NONE;
        end
    end

    always_comb begin
        mode_next = mode_reg;
        case (ev)
            EV_TIME: begin
                mode_next = MODE_TIME;
            end
            EV_TIMESET: begin
                mode_next = MODE_TSET;
            end
            EV_ALARM: begin
                mode_next = MODE_ASET;
            end
            EV_WATCH: begin
                if (mode_reg != MODE_TIME) begin
                    mode_next = MODE_WATCH;
                end else begin
                    mode_next = MODE_WATCH;
                end
            end
            default: begin
                mode_next = mode_reg;
            end
        endcase
    end

    always_comb begin
        logic [5:0] fld;
        logic       hsel;
        clk_next      = clk_reg;
        watch_next    = watch_reg;
        disp_next     = disp_reg;
        alh_next      = alh_reg;
        alm_next      = alm_reg;
        bch_next      = bch_reg;
        bcm_next      = bcm_reg;
        bca_next      = bca_reg;
        ts_hours_next = ts_hours_reg;
        al_hours_next = al_hours_reg;
        run_next      = run_reg;
        lap_next      = lap_reg;
        armed_next    = armed_reg;
        hb_next       = hb_reg;
        mb_next       = mb_reg;
        ring_next     = ring_reg;
        fld           = 6'd0;
        hsel          = (mode_reg == MODE_ASET) ? al_hours_reg : ts_hours_reg;

        case (mode_reg)
            MODE_TIME: begin
                disp_next = clk_reg;
                case (ev)
                    EV_TIMESET: begin
                        hb_next = 1'b0;
                        mb_next = 1'b0;
                        bch_next = 4'd0;
                        bcm_next = 4'd0;
                        ts_hours_next = 1'b1;
                    end
                    EV_ALARM: begin
                        hb_next = 1'b0;
                        mb_next = 1'b0;
                        bch_next = 4'd0;
                        bcm_next = 4'd0;
                        armed_next = 1'b0;
                        disp_next.h = alh_reg;
                        disp_next.m = alm_reg;
                        al_hours_next = 1'b1;
                    end
                    EV_WATCH: begin
                        watch_next = '0;
                        disp_next = '0;
                        lap_next = 1'b0;
                        run_next = 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
            MODE_TSET, MODE_ASET: begin
                if (hsel) begin
                    disp_next.h = (mode_reg == MODE_ASET) ? alh_reg : clk_reg.h;
                    bch_next = blink_advance(bch_reg, bdiv_reg);
                    if (bch_next == 4'd0) begin
                        hb_next = !hb_reg;
                    end
                end else begin
                    disp_next.m = (mode_reg == MODE_ASET) ? alm_reg : clk_reg.m;
                    bcm_next = blink_advance(bcm_reg, bdiv_reg);
                    if (bcm_next == 4'd0) begin
                        mb_next = !mb_reg;
                    end
                end
                case (ev)
                    EV_TIME: begin
                        hb_next = 1'b0;
                        mb_next = 1'b0;
                        bch_next = 4'd0;
                        bcm_next = 4'd0;
                    end
                    EV_TIMESET: begin
                        if (mode_reg == MODE_TSET) begin
                            if (ts_hours_reg) begin
                                hb_next = 1'b0;
                                bch_next = 4'd0;
                            end else begin
                                mb_next = 1'b0;
                                bcm_next = 4'd0;
                            end
                            ts_hours_next = !ts_hours_reg;
                        end else begin
                            hb_next = 1'b0;
                            mb_next = 1'b0;
                            bch_next = 4'd0;
                            bcm_next = 4'd0;
                            disp_next = clk_reg;
                            ts_hours_next = 1'b1;
                        end
                    end
                    EV_ALARM: begin
                        if (mode_reg == MODE_ASET) begin
                            if (al_hours_reg) begin
                                hb_next = 1'b0;
                                bch_next = 4'd0;
                            end else begin
                                armed_next = 1'b1;
                                mb_next = 1'b0;
                                bcm_next = 4'd0;
                            end
                            al_hours_next = !al_hours_reg;
                        end else begin
                            hb_next = 1'b0;
                            mb_next = 1'b0;
                            bch_next = 4'd0;
                            bcm_next = 4'd0;
                            armed_next = 1'b0;
                            disp_next.h = alh_reg;
                            disp_next.m = alm_reg;
                            al_hours_next = 1'b1;
                        end
                    end
                    EV_WATCH: begin
                        hb_next = 1'b0;
                        mb_next = 1'b0;
                        bch_next = 4'd0;
                        bcm_next = 4'd0;
                        watch_next = '0;
                        disp_next = '0;
                        lap_next = 1'b0;
                        run_next = 1'b0;
                    end
                    EV_PLUS, EV_MINUS: begin
                        if (mode_reg == MODE_TSET) begin
                            if (ts_hours_reg) begin
                                fld = step_field({1'b0, clk_reg.h}, HOURS_TOP, ev == EV_PLUS);
                                clk_next.h = fld[4:0];
                            end else begin
                                clk_next.m = step_field(clk_reg.m, MINUTES_TOP, ev == EV_PLUS);
                            end
                        end else begin
                            if (al_hours_reg) begin
                                fld = step_field({1'b0, alh_reg}, HOURS_TOP, ev == EV_PLUS);
                                alh_next = fld[4:0];
                            end else begin
                                alm_next = step_field(alm_reg, MINUTES_TOP, ev == EV_PLUS);
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
                if (run_reg) begin
                    watch_next = tick_hmst(watch_reg);
                    if (!lap_reg) begin
                        disp_next = watch_next;
                    end
                end
                case (ev)
                    EV_TIMESET: begin
                        hb_next = 1'b0;
                        mb_next = 1'b0;
                        bch_next = 4'd0;
                        bcm_next = 4'd0;
                        disp_next = clk_reg;
                        ts_hours_next = 1'b1;
                    end
                    EV_ALARM: begin
                        hb_next = 1'b0;
                        mb_next = 1'b0;
                        bch_next = 4'd0;
                        bcm_next = 4'd0;
                        armed_next = 1'b0;
                        disp_next.h = alh_reg;
                        disp_next.m = alm_reg;
                        al_hours_next = 1'b1;
                    end
                    EV_PLUS: begin
                        run_next = !run_reg;
                    end
                    EV_MINUS: begin
                        if (run_reg) begin
                            lap_next = !lap_reg;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        endcase

        clk_next = tick_hmst(clk_next);

        if (armed_next && clk_next.h == alh_next && clk_next.m == alm_next) begin
            bca_next = blink_advance(bca_reg, bdiv_reg);
            if (bca_next == 4'd0) begin
                ring_next = !ring_reg;
            end
        end else begin
            ring_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bdiv_reg <= BLINK_DIVIDE_RESET;
        end else if (cfg_we) begin
            bdiv_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_TIME;
            clk_reg      <= '0;
            watch_reg    <= '0;
            disp_reg     <= '0;
            alh_reg      <= '0;
            alm_reg      <= '0;
            bch_reg      <= '0;
            bcm_reg      <= '0;
            bca_reg      <= '0;
            ts_hours_reg <= 1'b1;
            al_hours_reg <= 1'b0;
            run_reg      <= 1'b0;
            lap_reg      <= 1'b0;
            armed_reg    <= 1'b0;
            hb_reg       <= 1'b0;
            mb_reg       <= 1'b0;
            ring_reg     <= 1'b0;
        end else if (in_xfer) begin
            mode_reg     <= mode_next;
            clk_reg      <= clk_next;
            watch_reg    <= watch_next;
            disp_reg     <= disp_next;
            alh_reg      <= alh_next;
            alm_reg      <= alm_next;
            bch_reg      <= bch_next;
            bcm_reg      <= bcm_next;
            bca_reg      <= bca_next;
            ts_hours_reg <= ts_hours_next;
            al_hours_reg <= al_hours_next;
            run_reg      <= run_next;
            lap_reg      <= lap_next;
            armed_reg    <= armed_next;
            hb_reg       <= hb_next;
            mb_reg       <= mb_next;
            ring_reg     <= ring_next;
        end
    end

    assign res.disp   = disp_next;
    assign res.mode   = mode_next;
    assign res.armed  = armed_next;
    assign res.hblink = hb_next;
    assign res.mblink = mb_next;
    assign res.ring   = ring_next;

    `DWC_ASSERT(a_ring_needs_armed, aclk, aresetn, ring_reg |-> armed_reg, "ring without armed alarm")
    `DWC_ASSERT(a_mode_holds_idle, aclk, aresetn, !in_xfer |=> $stable(mode_reg), "mode changed without transfer")

endmodule

### rtl/dwc_out_stage.sv
`include "digital_watch_controller_assert.svh"

module dwc_out_stage
    import dwc_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_xfer,
    input  res_t res,
    output logic in_ready,
    input  logic m_tready,
    output logic m_tvalid,
    output res_t res_out
);

    logic m_valid_reg;
    res_t res_reg;

    assign in_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_xfer) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign res_out  = res_reg;

    `DWC_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid_reg, "result valid after reset")
    `DWC_ASSERT(a_xfer_fills, aclk, aresetn, in_xfer |=> m_valid_reg, "accepted tick lost")
    `DWC_ASSERT(a_stall_holds, aclk, aresetn, (m_valid_reg && !m_tready) |=> (m_valid_reg && $stable(res_reg)), "stalled result changed")

endmodule

### rtl/digital_watch_controller.sv
// A result is registered in the output stage and appears on m_tdata in the cycle after its tick transfer on s_.
// Throughput: one tick per cycle when not stalled; the whole update of counters
// and mode logic is one combinational pass into the state and output registers.
// s_tready stays high while the output register is empty or being taken.
// Reset (aresetn low, synchronous): time mode, all counts zero,
// time-set hours selected, blink_divide 5, no result pending.
module digital_watch_controller
    import dwc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [3:0]           cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // plus_press, minus_press, time_press, timeset_press, alarm_press, stopwatch_press
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // show_hours, show_minutes, show_seconds, show_tenths, mode_now, alarm_armed,
    // hours_blink, minutes_blink, ring
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic in_xfer;
    res_t res;
    res_t res_out;

    assign in_xfer = s_tvalid && s_tready;

    dwc_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_xfer   (in_xfer),
        .buttons   (s_tdata[5:0]),
        .res       (res)
    );

    dwc_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_xfer  (in_xfer),
        .res      (res),
        .in_ready (s_tready),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .res_out  (res_out)
    );

    assign m_tdata = {5'd0, res_out.ring, res_out.mblink, res_out.hblink, res_out.armed,
                      res_out.mode, res_out.disp.t, res_out.disp.s, res_out.disp.m,
                      res_out.disp.h};

endmodule
